### sv/lwlu_pkg.sv
// Shared types, constants and the packed-triangle address function for the linkage update unit.
`timescale 1ns / 1ps
`default_nettype none

package lwlu_pkg;

   // Sizes of the stores.
   localparam int LEAVES      = 256;
   localparam int NODE_SLOTS  = 2 * LEAVES;
   localparam int STORE_DEPTH = LEAVES * (LEAVES + 1) / 2;

   // Field widths.
   localparam int NODE_W   = 9;
   localparam int ROW_W    = 8;
   localparam int COUNT_W  = 9;
   localparam int VALUE_W  = 32;
   localparam int WEIGHT_W = 31;
   localparam int SLOT_W   = 16;
   localparam int ENTRY_W  = VALUE_W + WEIGHT_W;

   // Item modes.
   typedef enum logic [1:0] {
      MODE_START = 2'd0,
      MODE_LOAD  = 2'd1,
      MODE_SCAN  = 2'd2,
      MODE_MERGE = 2'd3
   } mode_type;

   // Linkage methods.
   typedef enum logic [1:0] {
      LINK_AVERAGE  = 2'd0,
      LINK_WARD     = 2'd1,
      LINK_SINGLE   = 2'd2,
      LINK_COMPLETE = 2'd3
   } link_type;

   // Configuration register indexes.
   typedef enum logic [1:0] {
      CSR_LEAF_COUNT = 2'd0,
      CSR_METHOD     = 2'd1,
      CSR_WEIGHTED   = 2'd2,
      CSR_UNUSED     = 2'd3
   } csr_type;

   localparam logic [COUNT_W-1:0] LEAF_RESET = 9'd256;
   localparam logic [VALUE_W-1:0] VALUE_HI   = 32'h7FFF_FFFF;
   localparam logic [VALUE_W-1:0] VALUE_LO   = 32'h8000_0000;
   localparam logic [WEIGHT_W-1:0] WEIGHT_HI = 31'h7FFF_FFFF;

   // Address of entry (r, c) in the packed lower triangle; order of r and c does not matter.
   function automatic logic [SLOT_W-1:0] slot_index(input logic [ROW_W-1:0] r,
                                                    input logic [ROW_W-1:0] c);
      logic [ROW_W-1:0] hi_r;
      logic [ROW_W-1:0] lo_c;
      logic [16:0]      tri_n;
      hi_r  = (r < c) ? c : r;
      lo_c  = (r < c) ? r : c;
      tri_n = {9'd0, hi_r} * ({9'd0, hi_r} + 17'd1);
      return tri_n[16:1] + {8'd0, lo_c};
   endfunction

endpackage

`default_nettype wire

### sv/lance_williams_linkage_update_unit.sv
// Top level of the Lance-Williams linkage update unit: sequencer, memories and divider.
//
//   channel   ports                                   handshake
//   -------   -------------------------------------   -----------------------------------
//   request   req_mode .. req_last_key                word taken when start high, busy low
//   response  rsp_similarity .. rsp_last_out          one word per request, rsp_valid strobe
//   config    csr_we, csr_index, csr_wdata            written on any edge with csr_we high
//
// A start makes one pass over the 512-entry node map and the row tables.
// A merge visits each other active row: for single or complete linkage or a zero weight sum
// the new entry is written directly, while average, weighted and Ward linkage pass it through
// the 32-step bit-serial divider (skipped when the quotient saturates); then each
// active-list entry behind the removed row is shifted down one place.
// Reset runs the same pass over the node map and row tables; busy is high meanwhile.
// The response has no back-pressure: each word is on the ports for exactly one cycle.
`timescale 1ns / 1ps
`default_nettype none

module lance_williams_linkage_update_unit
   import lwlu_pkg::*;
(
   input  wire                         clock,
   input  wire                         reset,
   input  wire                         start,
   output logic                        busy,
   input  wire  [1:0]                  req_mode,
   input  wire  [NODE_W-1:0]           req_first_node,
   input  wire  [NODE_W-1:0]           req_second_node,
   input  wire  [NODE_W-1:0]           req_created_node,
   input  wire  signed [VALUE_W-1:0]   req_entry_value,
   input  wire  [WEIGHT_W-1:0]         req_entry_weight,
   input  wire                         req_last_key,
   output logic                        rsp_valid,
   output logic signed [VALUE_W-1:0]   rsp_similarity,
   output logic                        rsp_status,
   output logic [COUNT_W-1:0]          rsp_active_rows,
   output logic                        rsp_last_out,
   input  wire                         csr_we,
   input  wire  [1:0]                  csr_index,
   input  wire  [COUNT_W-1:0]          csr_wdata
);

   typedef enum logic [4:0] {
      S_INIT, S_IDLE, S_MAPA, S_MAPB, S_POSA, S_LSTA, S_LSTB, S_CHK, S_SCAN,
      S_SZA, S_SZB, L_LIST, L_C, L_X, L_Y, S_MUL, S_ADD, S_ABS, S_RND, S_DCHK,
      S_DIV, S_DWR, S_SIZE, S_SH_RD, S_SH_WR, S_FIN
   } state_type;

   state_type state_ff;

   // Configuration registers.
   logic [COUNT_W-1:0] leaf_count_ff;
   logic [1:0]         method_ff;
   logic               weighted_ff;

   // Item and sequencer registers.
   logic [1:0]          mode_ff;
   logic [NODE_W-1:0]   n1_ff, n2_ff, nn_ff;
   logic                last_ff;
   logic [NODE_W-1:0]   idx_ff;
   logic                init_rsp_ff;
   logic [COUNT_W-1:0]  n_start_ff;
   logic [COUNT_W-1:0]  total_ff;
   logic [ROW_W-1:0]    ra_ff, rb_ff, a_ff, b_ff, c_ff;
   logic [COUNT_W-1:0]  pa_ff, pb_ff, posb_ff;
   logic                pa_ok_ff, pb_ok_ff, act_a_ff;
   logic [COUNT_W-1:0]  wa_ff, wb_ff, wc_ff;
   logic signed [VALUE_W-1:0] cab_ff, x_ff, y_ff;
   logic [WEIGHT_W-1:0] wx_ff, wy_ff, wnew_ff;
   logic [COUNT_W-1:0]  p_ff, i_ff;
   logic [1:0]          term_ff;
   logic signed [64:0]  prod_ff;
   logic signed [65:0]  acc_ff;
   logic [31:0]         den_ff;
   logic                neg_ff, sat_ff;
   logic [64:0]         magp_ff;
   logic [31:0]         rem_ff, quo_ff;
   logic [4:0]          dcnt_ff;

   // Response registers.
   logic                      rsp_valid_ff;
   logic signed [VALUE_W-1:0] rsp_similarity_ff;
   logic                      rsp_status_ff;
   logic [COUNT_W-1:0]        rsp_active_rows_ff;
   logic                      rsp_last_out_ff;

   // Memory ports.
   logic                store_we;
   logic [SLOT_W-1:0]   store_addr;
   logic [ENTRY_W-1:0]  store_wdata, store_q;
   logic                map_we;
   logic [NODE_W-1:0]   map_addr;
   logic [ROW_W-1:0]    map_wdata, map_q;
   logic                size_we;
   logic [ROW_W-1:0]    size_addr;
   logic [COUNT_W-1:0]  size_wdata, size_q;
   logic                list_we;
   logic [ROW_W-1:0]    list_addr;
   logic [ROW_W-1:0]    list_wdata, list_q;
   logic                pos_we;
   logic [ROW_W-1:0]    pos_addr;
   logic [COUNT_W-1:0]  pos_wdata, pos_q;
   logic [ROW_W-1:0]    slot_r, slot_c;

   logic [ENTRY_W-1:0]  store_mem [0:STORE_DEPTH-1];
   logic [ROW_W-1:0]    map_mem   [0:NODE_SLOTS-1];
   logic [COUNT_W-1:0]  size_mem  [0:LEAVES-1];
   logic [ROW_W-1:0]    list_mem  [0:LEAVES-1];
   logic [COUNT_W-1:0]  pos_mem   [0:LEAVES-1];

   // Effective leaf count and node limit.
   logic [COUNT_W-1:0] eff_n;
   logic [9:0]         lim;
   logic               load_bad, scan_bad, merge_bad;
   logic               chk_ok;
   logic [ROW_W-1:0]   row_lo, row_hi;
   logic               use_ward;
   logic [1:0]         last_term;
   logic signed [32:0] coef;
   logic signed [VALUE_W-1:0] mval;
   logic signed [64:0] prod_in;
   logic signed [65:0] acc_neg;
   logic [31:0]        sw_now;
   logic signed [VALUE_W-1:0] y_now, x_sel;
   logic signed [VALUE_W-1:0] pick_v;
   logic [32:0]        div_t;
   logic [31:0]        div_q;
   logic [VALUE_W-1:0] div_v;
   logic [NODE_W-1:0]  i_next;

   always_comb begin
      eff_n = leaf_count_ff;
      if (leaf_count_ff < 9'd2) begin
         eff_n = 9'd2;
      end else if (leaf_count_ff > LEAF_RESET) begin
         eff_n = LEAF_RESET;
      end
   end
   assign lim = {eff_n, 1'b0};

   // Range checks on the incoming word.
   assign load_bad  = (req_first_node >= eff_n) || (req_second_node >= eff_n);
   assign scan_bad  = ({1'b0, req_first_node} >= lim) || ({1'b0, req_second_node} >= lim);
   assign merge_bad = scan_bad || ({1'b0, req_created_node} >= lim);

   // Second-row activity check and merged row order.
   assign chk_ok = act_a_ff && pb_ok_ff && (list_q == rb_ff);
   assign row_lo = (ra_ff < rb_ff) ? ra_ff : rb_ff;
   assign row_hi = (ra_ff < rb_ff) ? rb_ff : ra_ff;

   // Multiplier operands for the update terms.
   assign use_ward  = !weighted_ff && (method_ff == LINK_WARD);
   assign last_term = use_ward ? 2'd2 : 2'd1;

   always_comb begin
      case (term_ff)
         2'd0: begin
            mval = x_ff;
            if (weighted_ff) begin
               coef = $signed({2'b00, wx_ff});
            end else if (use_ward) begin
               coef = $signed({23'd0, {1'b0, wa_ff} + {1'b0, wc_ff}});
            end else begin
               coef = $signed({24'd0, wa_ff});
            end
         end
         2'd1: begin
            mval = y_ff;
            if (weighted_ff) begin
               coef = $signed({2'b00, wy_ff});
            end else if (use_ward) begin
               coef = $signed({23'd0, {1'b0, wb_ff} + {1'b0, wc_ff}});
            end else begin
               coef = $signed({24'd0, wb_ff});
            end
         end
         2'd2: begin
            mval = cab_ff;
            coef = 33'sd0 - $signed({24'd0, wc_ff});
         end
         default: begin
            mval = 32'sd0;
            coef = 33'sd0;
         end
      endcase
   end

   assign prod_in = coef * mval;
   assign acc_neg = 66'sd0 - acc_ff;

   // Weight sum and max/min pick while the second entry is on the read port.
   assign y_now  = $signed(store_q[VALUE_W-1:0]);
   assign sw_now = {1'b0, wx_ff} + {1'b0, store_q[ENTRY_W-1:VALUE_W]};
   assign x_sel  = x_ff;
   always_comb begin
      if (method_ff == LINK_SINGLE) begin
         pick_v = (x_sel > y_now) ? x_sel : y_now;
      end else begin
         pick_v = (x_sel < y_now) ? x_sel : y_now;
      end
   end

   // One restoring divider step.
   assign div_t = {rem_ff, quo_ff[31]};

   // Rounded quotient with sign and saturation.
   assign div_q = quo_ff;
   always_comb begin
      if (!neg_ff) begin
         div_v = (sat_ff || div_q[31]) ? VALUE_HI : div_q;
      end else begin
         div_v = (sat_ff || (div_q > VALUE_LO)) ? VALUE_LO : (32'd0 - div_q);
      end
   end

   assign i_next = i_ff + 9'd1;

   // Memory address and write control.
   always_comb begin
      store_we    = 1'b0;
      store_wdata = '0;
      map_we      = 1'b0;
      map_addr    = '0;
      map_wdata   = '0;
      size_we     = 1'b0;
      size_addr   = '0;
      size_wdata  = '0;
      list_we     = 1'b0;
      list_addr   = '0;
      list_wdata  = '0;
      pos_we      = 1'b0;
      pos_addr    = '0;
      pos_wdata   = '0;
      slot_r      = a_ff;
      slot_c      = c_ff;
      case (state_ff)
         S_INIT: begin
            map_we    = 1'b1;
            map_addr  = idx_ff;
            map_wdata = ((idx_ff != 9'd0) && (idx_ff <= n_start_ff)) ?
                        ROW_W'(idx_ff - 9'd1) : '0;
            size_we    = !idx_ff[8];
            size_addr  = idx_ff[7:0];
            size_wdata = 9'd1;
            list_we    = !idx_ff[8];
            list_addr  = idx_ff[7:0];
            list_wdata = idx_ff[7:0];
            pos_we     = !idx_ff[8];
            pos_addr   = idx_ff[7:0];
            pos_wdata  = idx_ff;
         end
         S_IDLE: begin
            slot_r      = req_first_node[7:0];
            slot_c      = req_second_node[7:0];
            store_we    = start && (req_mode == MODE_LOAD) && !load_bad;
            store_wdata = {req_entry_weight, req_entry_value};
         end
         S_MAPA: begin
            map_addr = n1_ff;
         end
         S_MAPB: begin
            map_addr = n2_ff;
         end
         S_POSA: begin
            pos_addr = ra_ff;
         end
         S_LSTA: begin
            list_addr = pos_q[7:0];
            pos_addr  = rb_ff;
         end
         S_LSTB: begin
            list_addr = pos_q[7:0];
         end
         S_CHK: begin
            slot_r    = ra_ff;
            slot_c    = rb_ff;
            size_addr = row_lo;
         end
         S_SZA: begin
            size_addr = b_ff;
         end
         L_LIST: begin
            list_addr = p_ff[7:0];
         end
         L_C: begin
            slot_r    = a_ff;
            slot_c    = list_q;
            size_addr = list_q;
         end
         L_X: begin
            slot_r = b_ff;
            slot_c = c_ff;
         end
         L_Y: begin
            if (weighted_ff) begin
               store_we    = (sw_now == 32'd0);
               store_wdata = '0;
            end else if ((method_ff == LINK_SINGLE) || (method_ff == LINK_COMPLETE)) begin
               store_we    = 1'b1;
               store_wdata = {wx_ff, pick_v};
            end
         end
         S_DWR: begin
            store_we    = 1'b1;
            store_wdata = {wnew_ff, div_v};
         end
         S_SIZE: begin
            size_we    = !weighted_ff;
            size_addr  = a_ff;
            size_wdata = wa_ff + wb_ff;
         end
         S_SH_RD: begin
            list_addr = i_next[7:0];
         end
         S_SH_WR: begin
            list_we    = 1'b1;
            list_addr  = i_ff[7:0];
            list_wdata = list_q;
            pos_we     = 1'b1;
            pos_addr   = list_q;
            pos_wdata  = i_ff;
         end
         S_FIN: begin
            pos_we    = 1'b1;
            pos_addr  = b_ff;
            pos_wdata = LEAF_RESET;
            map_we    = 1'b1;
            map_addr  = nn_ff;
            map_wdata = a_ff;
         end
         default: begin
            slot_r = a_ff;
         end
      endcase
      store_addr = slot_index(slot_r, slot_c);
   end

   // Memories.
   always_ff @(posedge clock) begin
      if (store_we) begin
         store_mem[store_addr] <= store_wdata;
      end
      store_q <= store_mem[store_addr];
   end

   always_ff @(posedge clock) begin
      if (map_we) begin
         map_mem[map_addr] <= map_wdata;
      end
      map_q <= map_mem[map_addr];
   end

   always_ff @(posedge clock) begin
      if (size_we) begin
         size_mem[size_addr] <= size_wdata;
      end
      size_q <= size_mem[size_addr];
   end

   always_ff @(posedge clock) begin
      if (list_we) begin
         list_mem[list_addr] <= list_wdata;
      end
      list_q <= list_mem[list_addr];
   end

   always_ff @(posedge clock) begin
      if (pos_we) begin
         pos_mem[pos_addr] <= pos_wdata;
      end
      pos_q <= pos_mem[pos_addr];
   end

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         leaf_count_ff <= LEAF_RESET;
         method_ff     <= LINK_AVERAGE;
         weighted_ff   <= 1'b0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_LEAF_COUNT: leaf_count_ff <= csr_wdata;
            CSR_METHOD:     method_ff     <= csr_wdata[1:0];
            CSR_WEIGHTED:   weighted_ff   <= csr_wdata[0];
            default:        leaf_count_ff <= leaf_count_ff;
         endcase
      end
   end

   // Sequencer, datapath and response registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT;
         idx_ff       <= '0;
         init_rsp_ff  <= 1'b0;
         n_start_ff   <= LEAF_RESET;
         total_ff     <= LEAF_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= 1'b0;
         case (state_ff)
            S_INIT: begin
               idx_ff <= idx_ff + 9'd1;
               if (idx_ff == 9'(NODE_SLOTS - 1)) begin
                  total_ff <= n_start_ff;
                  state_ff <= S_IDLE;
                  if (init_rsp_ff) begin
                     rsp_valid_ff       <= 1'b1;
                     rsp_similarity_ff  <= '0;
                     rsp_status_ff      <= 1'b0;
                     rsp_active_rows_ff <= n_start_ff;
                     rsp_last_out_ff    <= last_ff;
                  end
               end
            end
            S_IDLE: begin
               if (start) begin
                  mode_ff <= req_mode;
                  n1_ff   <= req_first_node;
                  n2_ff   <= req_second_node;
                  nn_ff   <= req_created_node;
                  last_ff <= req_last_key;
                  case (req_mode)
                     MODE_START: begin
                        n_start_ff  <= eff_n;
                        idx_ff      <= '0;
                        init_rsp_ff <= 1'b1;
                        state_ff    <= S_INIT;
                     end
                     MODE_LOAD: begin
                        rsp_valid_ff       <= 1'b1;
                        rsp_similarity_ff  <= '0;
                        rsp_status_ff      <= load_bad;
                        rsp_active_rows_ff <= total_ff;
                        rsp_last_out_ff    <= req_last_key;
                     end
                     default: begin
                        if ((req_mode == MODE_SCAN) ? scan_bad : merge_bad) begin
                           rsp_valid_ff       <= 1'b1;
                           rsp_similarity_ff  <= '0;
                           rsp_status_ff      <= 1'b1;
                           rsp_active_rows_ff <= total_ff;
                           rsp_last_out_ff    <= req_last_key;
                        end else begin
                           state_ff <= S_MAPA;
                        end
                     end
                  endcase
               end
            end
            S_MAPA: begin
               state_ff <= S_MAPB;
            end
            S_MAPB: begin
               ra_ff    <= map_q;
               state_ff <= S_POSA;
            end
            S_POSA: begin
               rb_ff    <= map_q;
               state_ff <= S_LSTA;
            end
            S_LSTA: begin
               pa_ff    <= pos_q;
               pa_ok_ff <= pos_q < total_ff;
               state_ff <= S_LSTB;
            end
            S_LSTB: begin
               act_a_ff <= pa_ok_ff && (list_q == ra_ff);
               pb_ff    <= pos_q;
               pb_ok_ff <= pos_q < total_ff;
               state_ff <= S_CHK;
            end
            S_CHK: begin
               if (mode_ff == MODE_SCAN) begin
                  if (chk_ok) begin
                     state_ff <= S_SCAN;
                  end else begin
                     rsp_valid_ff       <= 1'b1;
                     rsp_similarity_ff  <= '0;
                     rsp_status_ff      <= 1'b1;
                     rsp_active_rows_ff <= total_ff;
                     rsp_last_out_ff    <= last_ff;
                     state_ff           <= S_IDLE;
                  end
               end else if (chk_ok && (ra_ff != rb_ff)) begin
                  a_ff     <= row_lo;
                  b_ff     <= row_hi;
                  posb_ff  <= (ra_ff < rb_ff) ? pb_ff : pa_ff;
                  state_ff <= S_SZA;
               end else begin
                  rsp_valid_ff       <= 1'b1;
                  rsp_similarity_ff  <= '0;
                  rsp_status_ff      <= 1'b1;
                  rsp_active_rows_ff <= total_ff;
                  rsp_last_out_ff    <= last_ff;
                  state_ff           <= S_IDLE;
               end
            end
            S_SCAN: begin
               rsp_valid_ff       <= 1'b1;
               rsp_similarity_ff  <= $signed(store_q[VALUE_W-1:0]);
               rsp_status_ff      <= 1'b0;
               rsp_active_rows_ff <= total_ff;
               rsp_last_out_ff    <= last_ff;
               state_ff           <= S_IDLE;
            end
            S_SZA: begin
               wa_ff    <= size_q;
               cab_ff   <= $signed(store_q[VALUE_W-1:0]);
               state_ff <= S_SZB;
            end
            S_SZB: begin
               wb_ff    <= size_q;
               p_ff     <= '0;
               state_ff <= L_LIST;
            end
            // Walk the active list, one row at a time.
            L_LIST: begin
               state_ff <= (p_ff < total_ff) ? L_C : S_SIZE;
            end
            L_C: begin
               c_ff <= list_q;
               if ((list_q == a_ff) || (list_q == b_ff)) begin
                  p_ff     <= p_ff + 9'd1;
                  state_ff <= L_LIST;
               end else begin
                  state_ff <= L_X;
               end
            end
            L_X: begin
               x_ff     <= $signed(store_q[VALUE_W-1:0]);
               wx_ff    <= store_q[ENTRY_W-1:VALUE_W];
               wc_ff    <= size_q;
               state_ff <= L_Y;
            end
            L_Y: begin
               y_ff    <= y_now;
               term_ff <= 2'd0;
               acc_ff  <= '0;
               if (weighted_ff) begin
                  den_ff  <= sw_now;
                  wnew_ff <= sw_now[31] ? WEIGHT_HI : sw_now[WEIGHT_W-1:0];
                  if (sw_now == 32'd0) begin
                     p_ff     <= p_ff + 9'd1;
                     state_ff <= L_LIST;
                  end else begin
                     state_ff <= S_MUL;
                  end
               end else begin
                  wnew_ff <= wx_ff;
                  if (use_ward) begin
                     den_ff <= {22'd0, {1'b0, wa_ff} + {1'b0, wb_ff} + {1'b0, wc_ff}};
                  end else begin
                     den_ff <= {22'd0, {1'b0, wa_ff} + {1'b0, wb_ff}};
                  end
                  if ((method_ff == LINK_SINGLE) || (method_ff == LINK_COMPLETE)) begin
                     p_ff     <= p_ff + 9'd1;
                     state_ff <= L_LIST;
                  end else begin
                     state_ff <= S_MUL;
                  end
               end
            end
            // Sum of products: each multiply is registered in S_MUL and accumulated in S_ADD.
            S_MUL: begin
               prod_ff  <= prod_in;
               state_ff <= S_ADD;
            end
            S_ADD: begin
               acc_ff  <= acc_ff + {prod_ff[64], prod_ff};
               term_ff <= term_ff + 2'd1;
               state_ff <= (term_ff == last_term) ? S_ABS : S_MUL;
            end
            S_ABS: begin
               neg_ff   <= acc_ff[65];
               magp_ff  <= acc_ff[65] ? acc_neg[64:0] : acc_ff[64:0];
               state_ff <= S_RND;
            end
            S_RND: begin
               magp_ff  <= magp_ff + {34'd0, den_ff[31:1]};
               state_ff <= S_DCHK;
            end
            S_DCHK: begin
               dcnt_ff <= '0;
               if (magp_ff[64:32] >= {1'b0, den_ff}) begin
                  sat_ff   <= 1'b1;
                  state_ff <= S_DWR;
               end else begin
                  sat_ff   <= 1'b0;
                  rem_ff   <= magp_ff[63:32];
                  quo_ff   <= magp_ff[31:0];
                  state_ff <= S_DIV;
               end
            end
            S_DIV: begin
               if (div_t >= {1'b0, den_ff}) begin
                  rem_ff <= 32'(div_t - {1'b0, den_ff});
                  quo_ff <= {quo_ff[30:0], 1'b1};
               end else begin
                  rem_ff <= div_t[31:0];
                  quo_ff <= {quo_ff[30:0], 1'b0};
               end
               dcnt_ff <= dcnt_ff + 5'd1;
               if (dcnt_ff == 5'd31) begin
                  state_ff <= S_DWR;
               end
            end
            S_DWR: begin
               p_ff     <= p_ff + 9'd1;
               state_ff <= L_LIST;
            end
            // Drop the higher row from the active list.
            S_SIZE: begin
               total_ff <= total_ff - 9'd1;
               i_ff     <= posb_ff;
               state_ff <= S_SH_RD;
            end
            S_SH_RD: begin
               state_ff <= (i_ff < total_ff) ? S_SH_WR : S_FIN;
            end
            S_SH_WR: begin
               i_ff     <= i_next;
               state_ff <= S_SH_RD;
            end
            S_FIN: begin
               rsp_valid_ff       <= 1'b1;
               rsp_similarity_ff  <= '0;
               rsp_status_ff      <= 1'b0;
               rsp_active_rows_ff <= total_ff;
               rsp_last_out_ff    <= last_ff;
               state_ff           <= S_IDLE;
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   // Weight of the second entry, captured while it is on the read port.
   always_ff @(posedge clock) begin
      if (state_ff == L_Y) begin
         wy_ff <= store_q[ENTRY_W-1:VALUE_W];
      end
   end

   assign busy            = (state_ff != S_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_similarity  = rsp_similarity_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_active_rows = rsp_active_rows_ff;
   assign rsp_last_out    = rsp_last_out_ff;

endmodule

`default_nettype wire

### tb/sv/tb_lance_williams_linkage_update_unit.sv
// Self-checking testbench for the Lance-Williams linkage update unit.
`timescale 1ns / 1ps

module tb_lance_williams_linkage_update_unit;
   import lwlu_pkg::*;

   localparam int IDLE_LIMIT = 100000;

   typedef struct {
      logic [1:0]          mode;
      logic [NODE_W-1:0]   n1;
      logic [NODE_W-1:0]   n2;
      logic [NODE_W-1:0]   nn;
      logic [VALUE_W-1:0]  value;
      logic [WEIGHT_W-1:0] weight;
      logic                last;
   } cmd_word_type;

   typedef struct {
      logic [VALUE_W-1:0]  sim;
      logic                status;
      logic [COUNT_W-1:0]  rows;
      logic                last;
   } sim_word_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic [1:0]          req_mode = '0;
   logic [NODE_W-1:0]   req_first_node = '0;
   logic [NODE_W-1:0]   req_second_node = '0;
   logic [NODE_W-1:0]   req_created_node = '0;
   logic [VALUE_W-1:0]  req_entry_value = '0;
   logic [WEIGHT_W-1:0] req_entry_weight = '0;
   logic                req_last_key = 1'b0;
   logic                rsp_valid;
   logic [VALUE_W-1:0]  rsp_similarity;
   logic                rsp_status;
   logic [COUNT_W-1:0]  rsp_active_rows;
   logic                rsp_last_out;
   logic                csr_we = 1'b0;
   logic [1:0]          csr_index = '0;
   logic [COUNT_W-1:0]  csr_wdata = '0;

   cmd_word_type pending_cmds[$];
   sim_word_type expected_words[$];
   int        errors = 0;
   int        gap_left = 0;
   int        calm_left = 0;
   int        idle_cycles = 0;

   // Shadow copy of the block state.
   logic signed [VALUE_W-1:0] pair_val[STORE_DEPTH];
   logic [WEIGHT_W-1:0]       pair_wt[STORE_DEPTH];
   int row_of_node[NODE_SLOTS];
   int csize[LEAVES];
   int alist[LEAVES];
   int lpos[LEAVES];
   int n_active;
   int cfg_leaves = 256;
   int cfg_method = 0;
   int cfg_weighted = 0;

   lance_williams_linkage_update_unit u_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_mode(req_mode), .req_first_node(req_first_node),
      .req_second_node(req_second_node), .req_created_node(req_created_node),
      .req_entry_value(req_entry_value), .req_entry_weight(req_entry_weight),
      .req_last_key(req_last_key), .rsp_valid(rsp_valid),
      .rsp_similarity(rsp_similarity), .rsp_status(rsp_status),
      .rsp_active_rows(rsp_active_rows), .rsp_last_out(rsp_last_out),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   // Clock generation.
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic int eff_leaves();
      if (cfg_leaves < 2) return 2;
      if (cfg_leaves > LEAVES) return LEAVES;
      return cfg_leaves;
   endfunction

   function automatic int pair_slot(int r, int c);
      int hi;
      int lo;
      hi = (r > c) ? r : c;
      lo = (r > c) ? c : r;
      return hi * (hi + 1) / 2 + lo;
   endfunction

   function automatic bit row_live(int r);
      return lpos[r] < n_active && alist[lpos[r]] == r;
   endfunction

   // Divide with rounding to nearest, ties away from zero, saturated to the value range.
   function automatic logic [VALUE_W-1:0] round_div(longint num, longint unsigned den);
      longint unsigned mag;
      longint unsigned q;
      bit neg;
      if (den == 0) return '0;
      neg = num < 0;
      mag = neg ? longint'(-num) : longint'(num);
      q = (mag + den / 2) / den;
      if (!neg && q > 64'h7FFF_FFFF) return VALUE_HI;
      if (neg && q > 64'h8000_0000) return VALUE_LO;
      return neg ? VALUE_W'(-q) : VALUE_W'(q);
   endfunction

   function automatic void restart_rows();
      int n;
      n = eff_leaves();
      for (int i = 0; i < LEAVES; i++) begin
         alist[i] = i;
         lpos[i] = i;
         csize[i] = 1;
      end
      for (int i = 0; i < NODE_SLOTS; i++) row_of_node[i] = 0;
      for (int i = 1; i <= n; i++) row_of_node[i] = i - 1;
      n_active = n;
   endfunction

   // Fold two clusters together; returns the error status.
   function automatic logic merge_rows(int n1, int n2, int nn);
      int lim;
      int ra;
      int rb;
      int a;
      int b;
      int c;
      int sac;
      int sbc;
      int pb;
      longint wa;
      longint wb;
      longint wc;
      longint wx;
      longint wy;
      longint sw;
      longint x;
      longint y;
      longint cab;
      logic [VALUE_W-1:0] v;
      lim = 2 * eff_leaves();
      if (n1 >= lim || n2 >= lim || nn >= lim) return 1'b1;
      ra = row_of_node[n1];
      rb = row_of_node[n2];
      if (ra == rb || !row_live(ra) || !row_live(rb)) return 1'b1;
      a = (ra < rb) ? ra : rb;
      b = (ra < rb) ? rb : ra;
      wa = csize[a];
      wb = csize[b];
      cab = pair_val[pair_slot(a, b)];
      for (int p = 0; p < n_active; p++) begin
         c = alist[p];
         if (c == a || c == b) continue;
         sac = pair_slot(a, c);
         sbc = pair_slot(b, c);
         x = pair_val[sac];
         y = pair_val[sbc];
         if (cfg_weighted != 0) begin
            wx = pair_wt[sac];
            wy = pair_wt[sbc];
            sw = wx + wy;
            pair_val[sac] = round_div(wx * x + wy * y, sw);
            pair_wt[sac] = (sw > longint'(WEIGHT_HI)) ? WEIGHT_HI : WEIGHT_W'(sw);
            continue;
         end
         wc = csize[c];
         case (link_type'(cfg_method))
            LINK_AVERAGE:  v = round_div(wa * x + wb * y, wa + wb);
            LINK_WARD:     v = round_div((wa + wc) * x + (wb + wc) * y - wc * cab,
                                         wa + wb + wc);
            LINK_SINGLE:   v = VALUE_W'((x > y) ? x : y);
            default:       v = VALUE_W'((x < y) ? x : y);
         endcase
         pair_val[sac] = v;
      end
      if (cfg_weighted == 0) csize[a] = int'(wa + wb);
      pb = lpos[b];
      n_active--;
      for (int i = pb; i < n_active; i++) begin
         alist[i] = alist[i + 1];
         lpos[alist[i]] = i;
      end
      lpos[b] = LEAVES;
      row_of_node[nn] = a;
      return 1'b0;
   endfunction

   // Apply one word to the shadow state and return the response it must produce.
   function automatic sim_word_type predict_word(cmd_word_type w);
      sim_word_type r;
      int lim;
      int ra;
      int rb;
      r.sim = '0;
      r.status = 1'b0;
      r.last = w.last;
      case (mode_type'(w.mode))
         MODE_START: restart_rows();
         MODE_LOAD: begin
            if (w.n1 >= eff_leaves() || w.n2 >= eff_leaves()) r.status = 1'b1;
            else begin
               pair_val[pair_slot(w.n1, w.n2)] = w.value;
               pair_wt[pair_slot(w.n1, w.n2)] = w.weight;
            end
         end
         MODE_SCAN: begin
            lim = 2 * eff_leaves();
            if (w.n1 >= lim || w.n2 >= lim) r.status = 1'b1;
            else begin
               ra = row_of_node[w.n1];
               rb = row_of_node[w.n2];
               if (!row_live(ra) || !row_live(rb)) r.status = 1'b1;
               else r.sim = pair_val[pair_slot(ra, rb)];
            end
         end
         default: r.status = merge_rows(w.n1, w.n2, w.nn);
      endcase
      r.rows = COUNT_W'(n_active);
      return r;
   endfunction

   task automatic send_word(cmd_word_type w);
      pending_cmds.push_back(w);
      expected_words.push_back(predict_word(w));
   endtask

   function automatic cmd_word_type make_word(mode_type m, int n1, int n2, int nn);
      cmd_word_type w;
      w.mode = m;
      w.n1 = NODE_W'(n1);
      w.n2 = NODE_W'(n2);
      w.nn = NODE_W'(nn);
      case ($urandom_range(0, 7))
         0: w.value = VALUE_HI;
         1: w.value = VALUE_LO;
         2: w.value = VALUE_W'($signed($urandom_range(0, 32'h6_0000)) - 32'sh3_0000);
         default: w.value = $urandom;
      endcase
      case ($urandom_range(0, 5))
         0: w.weight = '0;
         1: w.weight = WEIGHT_HI;
         2: w.weight = WEIGHT_W'($urandom_range(0, 32'h3_0000));
         default: w.weight = WEIGHT_W'($urandom);
      endcase
      w.last = 1'($urandom_range(0, 1));
      return w;
   endfunction

   // Some node currently mapped to row r, or -1 when none is.
   function automatic int node_for_row(int r);
      int hits[$];
      for (int j = 0; j < 2 * eff_leaves(); j++)
         if (row_of_node[j] == r) hits.push_back(j);
      if (hits.size() == 0) return -1;
      return hits[$urandom_range(0, hits.size() - 1)];
   endfunction

   task automatic wait_drained();
      while (pending_cmds.size() != 0 || expected_words.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   task automatic write_reg(csr_type idx, int value);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= COUNT_W'(value);
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_LEAF_COUNT: cfg_leaves = value & 9'h1FF;
         CSR_METHOD:     cfg_method = value & 3;
         CSR_WEIGHTED:   cfg_weighted = value & 1;
         default: ;
      endcase
   endtask

   task automatic load_all_pairs();
      int n;
      n = eff_leaves();
      for (int r = 0; r < n; r++)
         for (int c = 0; c <= r; c++) begin
            if ($urandom_range(0, 1)) send_word(make_word(MODE_LOAD, r, c, 0));
            else send_word(make_word(MODE_LOAD, c, r, 0));
         end
   endtask

   // One random word: mostly legal merges and scans, some loads, restarts and noise.
   task automatic random_word();
      int pick;
      int p1;
      int p2;
      int na;
      int nb;
      int lim;
      cmd_word_type w;
      pick = $urandom_range(0, 99);
      lim = 2 * eff_leaves();
      na = -1;
      nb = -1;
      if (pick < 70 && n_active >= 2) begin
         p1 = $urandom_range(0, n_active - 1);
         p2 = $urandom_range(0, n_active - 1);
         if (p1 == p2 && pick >= 40) p2 = p1;
         else if (p1 == p2) p2 = (p1 + 1) % n_active;
         na = node_for_row(alist[p1]);
         nb = node_for_row(alist[p2]);
      end
      if (pick < 40 && na >= 0 && nb >= 0) begin
         send_word(make_word(MODE_MERGE, na, nb, $urandom_range(0, lim - 1)));
      end else if (pick < 70 && na >= 0 && nb >= 0) begin
         send_word(make_word(MODE_SCAN, na, nb, $urandom));
      end else if (pick < 80) begin
         send_word(make_word(MODE_LOAD, $urandom_range(0, eff_leaves() - 1),
                             $urandom_range(0, eff_leaves() - 1), $urandom));
      end else if (pick < 85) begin
         send_word(make_word(MODE_START, $urandom, $urandom, $urandom));
      end else begin
         w = make_word(mode_type'($urandom_range(0, 3)), $urandom, $urandom, $urandom);
         if ($urandom_range(0, 1)) begin
            w.n1 = NODE_W'($urandom_range(0, lim - 1));
            w.n2 = NODE_W'($urandom_range(0, lim - 1));
         end
         send_word(w);
      end
   endtask

   // Stimulus.
   initial begin
      int keys_r[$];
      int keys_c[$];
      int k;
      restart_rows();
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Directed checks under the reset configuration.
      send_word(make_word(MODE_LOAD, 0, 0, 0));
      send_word(make_word(MODE_LOAD, 1, 0, 0));
      send_word(make_word(MODE_LOAD, 254, 255, 0));
      send_word(make_word(MODE_LOAD, 255, 255, 0));
      send_word(make_word(MODE_SCAN, 1, 1, 0));
      send_word(make_word(MODE_SCAN, 0, 2, 0));
      send_word(make_word(MODE_SCAN, 256, 255, 0));
      send_word(make_word(MODE_SCAN, 256, 256, 0));
      send_word(make_word(MODE_LOAD, 256, 3, 0));
      send_word(make_word(MODE_LOAD, 5, 511, 0));
      send_word(make_word(MODE_MERGE, 1, 1, 300));
      send_word(make_word(MODE_MERGE, 0, 1, 511));
      wait_drained();

      // Small matrices under every method, both weight modes and clamped leaf counts.
      for (int ph = 0; ph < 13; ph++) begin
         case (ph)
            0: k = 2;
            1: k = 1;
            2: k = 0;
            3: k = 16;
            default: k = $urandom_range(3, 12);
         endcase
         write_reg(CSR_LEAF_COUNT, k);
         write_reg(CSR_METHOD, ph % 4);
         write_reg(CSR_WEIGHTED, (ph % 3 == 2) ? 1 : 0);
         send_word(make_word(MODE_START, $urandom, $urandom, $urandom));
         load_all_pairs();
         repeat (40) random_word();
         wait_drained();
      end

      // Largest matrix: loads and scans of written entries only; a clamped count too.
      for (int ph = 0; ph < 2; ph++) begin
         write_reg(CSR_LEAF_COUNT, ph == 0 ? 256 : 9'h1FF);
         write_reg(CSR_METHOD, ph == 0 ? LINK_SINGLE : LINK_COMPLETE);
         write_reg(CSR_WEIGHTED, 0);
         send_word(make_word(MODE_START, 0, 0, 0));
         keys_r.delete();
         keys_c.delete();
         for (int i = 0; i < 12; i++) begin
            keys_r.push_back($urandom_range(0, 255));
            keys_c.push_back($urandom_range(0, 255));
            send_word(make_word(MODE_LOAD, keys_r[i], keys_c[i], 0));
         end
         for (int i = 0; i < 12; i++)
            send_word(make_word(MODE_SCAN, keys_c[i] + 1, keys_r[i] + 1, 0));
         send_word(make_word(MODE_LOAD, $urandom_range(256, 511), 0, 0));
         wait_drained();
      end

      repeat (50) @(posedge clock);
      if (errors == 0) $display("[lance_williams_linkage_update_unit] OK");
      else $display("[lance_williams_linkage_update_unit] ERROR");
      $finish;
   end

   // Driver: presents queued words, with random gaps and calm stretches.
   always @(posedge clock) begin
      cmd_word_type w;
      if (!reset && !(start && busy)) begin
         if (gap_left > 0) begin
            gap_left--;
            start <= 1'b0;
         end else if (pending_cmds.size() != 0) begin
            w = pending_cmds.pop_front();
            req_mode <= w.mode;
            req_first_node <= w.n1;
            req_second_node <= w.n2;
            req_created_node <= w.nn;
            req_entry_value <= w.value;
            req_entry_weight <= w.weight;
            req_last_key <= w.last;
            start <= 1'b1;
            if (calm_left > 0) calm_left--;
            else if ($urandom_range(0, 99) == 0) calm_left = $urandom_range(20, 80);
            else if ($urandom_range(0, 9) < 6) gap_left = 0;
            else if ($urandom_range(0, 9) < 8) gap_left = $urandom_range(1, 3);
            else gap_left = $urandom_range(10, 40);
         end else begin
            start <= 1'b0;
         end
      end
   end

   task automatic report_mismatch(string field, longint got, longint want);
      $display("mismatch on %s: got %0h, expected %0h at %0t", field, got, want, $realtime);
      errors++;
   endtask

   // Monitor: each response word against the oldest expectation.
   always @(posedge clock) begin
      sim_word_type e;
      if (!reset && rsp_valid) begin
         if (expected_words.size() == 0) begin
            $display("response word with nothing expected at %0t", $realtime);
            errors++;
         end else begin
            e = expected_words.pop_front();
            if (rsp_similarity !== e.sim) report_mismatch("similarity", rsp_similarity, e.sim);
            if (rsp_status !== e.status) report_mismatch("status", rsp_status, e.status);
            if (rsp_active_rows !== e.rows)
               report_mismatch("active_rows", rsp_active_rows, e.rows);
            if (rsp_last_out !== e.last) report_mismatch("last_out", rsp_last_out, e.last);
         end
      end
   end

   // Watchdog on cycles with no word moving either way.
   always @(posedge clock) begin
      if ((start && !busy) || rsp_valid) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("[lance_williams_linkage_update_unit] ERROR");
         $finish;
      end
   end

endmodule
